// ===== design/serial_command_line_decoder_macros.svh =====
// ---------------------------------------------------------------------------
// Serial command line decoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_DECODER_MACROS_SVH
`define SERIAL_COMMAND_LINE_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/scld_pkg.sv =====
// ---------------------------------------------------------------------------
// Serial command line decoder package
// Sizes, parse phase and radix codes, the line-end struct and character tests.
// ---------------------------------------------------------------------------
package scld_pkg;

    localparam int KEY_SLOTS  = 8;
    localparam int LINE_BYTES = 32;

    localparam int KEY_TABLE_W = 64;
    localparam int KEY_COUNT_W = 4;
    localparam int INDEX_W     = 3;
    localparam int VALUE_W     = 31;
    localparam int POS_W       = $clog2(LINE_BYTES);
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 64;

    localparam logic [POS_W-1:0]   POS_LIMIT = POS_W'(LINE_BYTES - 1);
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // Parse phases.
    localparam logic [2:0] PH_LETTER = 3'd0;
    localparam logic [2:0] PH_SPACE  = 3'd1;
    localparam logic [2:0] PH_FIRST  = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_PREFIX = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;
    localparam logic [2:0] PH_SKIP   = 3'd6;

    // Number radix codes.
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_KEY_TABLE = 1'b0;
    localparam logic REG_KEY_COUNT = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [7:0]         letter;
        logic [VALUE_W-1:0] value;
    } t_line_end;

    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] index;
    } t_key_hit;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Returns {valid, digit value} for a byte in the given radix.
    function automatic logic [4:0] digit_of(logic [7:0] c, logic [1:0] radix);
        logic       v;
        logic [3:0] d;
        v = 1'b0;
        d = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 1'b1;
            d = c[3:0];
        end else if (radix == RADIX_HEX &&
                     ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))) begin
            v = 1'b1;
            d = c[3:0] + 4'd9;
        end
        if (radix == RADIX_OCT && d > 4'd7) begin
            v = 1'b0;
        end
        return {v, d};
    endfunction

endpackage

// ===== design/scld_if.sv =====
// ---------------------------------------------------------------------------
// Serial command line decoder channels
// Valid/ready channels for received bytes and for decoded commands.
// ---------------------------------------------------------------------------
interface scld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface scld_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command_index;
    logic [7:0]  command_letter;
    logic [30:0] command_value;

    modport source (output valid, output command_index, output command_letter,
                    output command_value, input ready);
    modport sink (input valid, input command_index, input command_letter,
                  input command_value, output ready);
endinterface

// ===== design/scld_parser.sv =====
// ---------------------------------------------------------------------------
// Serial command line decoder parser
// Holds the per-line parse registers and advances them by one byte per step.
// ---------------------------------------------------------------------------
module scld_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output scld_pkg::t_line_end o_end
);
    import scld_pkg::*;

    logic [2:0]         r_phase,  n_phase;
    logic [7:0]         r_letter, n_letter;
    logic [1:0]         r_radix,  n_radix;
    logic [VALUE_W-1:0] r_acc,    n_acc;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic               r_ended,  n_ended;

    logic [4:0]       w_dig_oct;
    logic [4:0]       w_dig_hex;
    logic [4:0]       w_dig_cur;
    logic             w_do_acc;
    logic [1:0]       w_acc_radix;
    logic [3:0]       w_acc_digit;
    logic [POS_W-1:0] w_pos_inc;
    logic             w_done;

    // acc * radix + digit, saturated. The multiply is shifts and one add.
    function automatic logic [VALUE_W-1:0] accumulate(logic [VALUE_W-1:0] acc,
                                                      logic [1:0] radix,
                                                      logic [3:0] d);
        logic [VALUE_W+3:0] prod;
        logic [VALUE_W+4:0] sum;
        case (radix)
            RADIX_HEX: prod = {acc, 4'b0000};
            RADIX_OCT: prod = {1'b0, acc, 3'b000};
            default:   prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
        endcase
        sum = {1'b0, prod} + {{(VALUE_W+1){1'b0}}, d};
        if (sum > {5'b00000, VALUE_MAX}) begin
            return VALUE_MAX;
        end
        return sum[VALUE_W-1:0];
    endfunction

    assign w_dig_oct = digit_of(i_byte, RADIX_OCT);
    assign w_dig_hex = digit_of(i_byte, RADIX_HEX);
    assign w_dig_cur = digit_of(i_byte, r_radix);
    assign w_pos_inc = r_pos + POS_W'(1);

    always_comb begin
        n_phase     = r_phase;
        n_letter    = r_letter;
        n_radix     = r_radix;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_ended     = r_ended;
        w_do_acc    = 1'b0;
        w_acc_radix = r_radix;
        w_acc_digit = w_dig_cur[3:0];
        w_done      = 1'b0;
        o_end       = '0;

        if (i_step) begin
            if (r_phase == PH_SKIP) begin
                if (i_byte == CH_NEWLINE) begin
                    n_phase  = PH_LETTER;
                    n_letter = '0;
                    n_radix  = RADIX_DEC;
                    n_acc    = '0;
                    n_pos    = '0;
                    n_ended  = 1'b0;
                end
            end else begin
                unique case (r_phase)
                    PH_LETTER: begin
                        if (is_letter(i_byte)) begin
                            n_letter = i_byte;
                            n_phase  = PH_SPACE;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SPACE: begin
                        n_phase = is_blank(i_byte) ? PH_FIRST : PH_SKIP;
                    end
                    PH_FIRST: begin
                        if (i_byte == "0") begin
                            n_phase = PH_ZERO;
                        end else if (i_byte >= "1" && i_byte <= "9") begin
                            n_radix     = RADIX_DEC;
                            w_do_acc    = 1'b1;
                            w_acc_radix = RADIX_DEC;
                            w_acc_digit = i_byte[3:0];
                            n_phase     = PH_DIGITS;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_ZERO: begin
                        if (!r_ended) begin
                            if (i_byte == "x" || i_byte == "X") begin
                                n_phase = PH_PREFIX;
                            end else if (w_dig_oct[4]) begin
                                n_radix     = RADIX_OCT;
                                w_do_acc    = 1'b1;
                                w_acc_radix = RADIX_OCT;
                                w_acc_digit = w_dig_oct[3:0];
                                n_phase     = PH_DIGITS;
                            end else begin
                                n_ended = 1'b1;
                            end
                        end
                    end
                    PH_PREFIX: begin
                        if (!r_ended) begin
                            if (w_dig_hex[4]) begin
                                n_radix     = RADIX_HEX;
                                w_do_acc    = 1'b1;
                                w_acc_radix = RADIX_HEX;
                                w_acc_digit = w_dig_hex[3:0];
                                n_phase     = PH_DIGITS;
                            end else begin
                                n_ended = 1'b1;
                            end
                        end
                    end
                    PH_DIGITS: begin
                        if (!r_ended) begin
                            if (w_dig_cur[4]) begin
                                w_do_acc = 1'b1;
                            end else begin
                                n_ended = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase

                // The accumulator is still zero when the first digit arrives.
                if (w_do_acc) begin
                    n_acc = accumulate(r_acc, w_acc_radix, w_acc_digit);
                end

                n_pos  = w_pos_inc;
                w_done = (i_byte == CH_NEWLINE) || (w_pos_inc >= POS_LIMIT);

                if (w_done) begin
                    o_end.valid  = (n_phase == PH_ZERO) || (n_phase == PH_PREFIX) ||
                                   (n_phase == PH_DIGITS);
                    o_end.letter = n_letter;
                    o_end.value  = n_acc;
                    // A line cut at the length limit drops the rest up to newline.
                    n_phase  = (i_byte == CH_NEWLINE) ? PH_LETTER : PH_SKIP;
                    n_letter = '0;
                    n_radix  = RADIX_DEC;
                    n_acc    = '0;
                    n_pos    = '0;
                    n_ended  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LETTER;
            r_letter <= '0;
            r_radix  <= RADIX_DEC;
            r_acc    <= '0;
            r_pos    <= '0;
            r_ended  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_letter <= n_letter;
            r_radix  <= n_radix;
            r_acc    <= n_acc;
            r_pos    <= n_pos;
            r_ended  <= n_ended;
        end
    end

endmodule

// ===== design/scld_key_match.sv =====
// ---------------------------------------------------------------------------
// Serial command line decoder key match
// Compares a letter against the active key slots; the lowest slot wins.
// ---------------------------------------------------------------------------
module scld_key_match (
    input  logic [scld_pkg::KEY_TABLE_W-1:0] i_key_table,
    input  logic [scld_pkg::KEY_COUNT_W-1:0] i_key_count,
    input  logic [7:0]                       i_letter,
    output scld_pkg::t_key_hit               o_hit
);
    import scld_pkg::*;

    always_comb begin
        o_hit = '0;
        // Walk downwards so that the lowest matching slot is left standing.
        for (int k = KEY_SLOTS - 1; k >= 0; k--) begin
            if (KEY_COUNT_W'(k) < i_key_count && i_key_table[8*k +: 8] == i_letter) begin
                o_hit.hit   = 1'b1;
                o_hit.index = INDEX_W'(k);
            end
        end
    end

endmodule

// ===== design/serial_command_line_decoder.sv =====
// ---------------------------------------------------------------------------
// Serial command line decoder
// Parses "letter, blank, number" text lines and emits matched commands.
// ---------------------------------------------------------------------------
// Takes one received byte per clock and turns each well-formed line into at
// most one command request carrying the matching key slot, the letter and the
// number (decimal, octal after a leading zero, hex after 0x, saturated at
// 2147483647). A byte is held in an input register, then the parse registers
// and the key compare update from it into the result register, so the final
// byte of a line passes the input register and then the result register, and
// the sustained rate is one byte per clock. The only stall comes from a held
// result: while a command waits to be taken, the byte behind it waits too.
// Key table and key count must be written over the APB port while the line is
// idle (the block does not enforce it); key_table is at byte address 0 and key_count at byte address 8.
module serial_command_line_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    scld_byte_if.sink                       i_rx,
    scld_cmd_if.source                      o_cmd,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [scld_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [scld_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [scld_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import scld_pkg::*;

`include "serial_command_line_decoder_macros.svh"

    logic [KEY_TABLE_W-1:0] r_key_table;
    logic [KEY_COUNT_W-1:0] r_key_count;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic [7:0]         r_out_letter;
    logic [VALUE_W-1:0] r_out_value;

    logic      w_step;
    logic      w_emit;
    t_line_end w_end;
    t_key_hit  w_hit;
    logic [5:0] w_out_key_bit;

    // Configuration port. Only bit 3 of the address is decoded.
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_KEY_COUNT) ?
                    {{(CFG_DATA_W-KEY_COUNT_W){1'b0}}, r_key_count} : r_key_table;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_table <= '0;
            r_key_count <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[3] == REG_KEY_COUNT) begin
                r_key_count <= pwdata[KEY_COUNT_W-1:0];
            end else begin
                r_key_table <= pwdata;
            end
        end
    end

    // The held byte is parsed once the result register is free or being taken.
    assign w_step     = r_in_valid && (!r_out_valid || o_cmd.ready);
    assign i_rx.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    scld_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_end   (w_end)
    );

    scld_key_match u_key_match (
        .i_key_table (r_key_table),
        .i_key_count (r_key_count),
        .i_letter    (w_end.letter),
        .o_hit       (w_hit)
    );

    assign w_emit = w_end.valid && w_hit.hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_emit;
        end else if (o_cmd.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out_index  <= w_hit.index;
            r_out_letter <= w_end.letter;
            r_out_value  <= w_end.value;
        end
    end

    assign o_cmd.valid          = r_out_valid;
    assign o_cmd.command_index  = r_out_index;
    assign o_cmd.command_letter = r_out_letter;
    assign o_cmd.command_value  = r_out_value;

    assign w_out_key_bit = {o_cmd.command_index, 3'b000};

    `SCLD_ASSERT_NOW(a_key_agrees, o_cmd.valid, r_key_table[w_out_key_bit +: 8] == o_cmd.command_letter, "command letter differs from its key slot")
    `SCLD_ASSERT_NOW(a_slot_in_use, o_cmd.valid, {1'b0, o_cmd.command_index} < r_key_count, "command slot beyond the key count")
    `SCLD_ASSERT_NEXT(a_byte_held, r_in_valid && !w_step, r_in_valid && $stable(r_in_byte), "held byte lost before it was parsed")
    `SCLD_ASSERT_NEXT(a_no_spurious, !w_step && !r_out_valid, !r_out_valid, "command request raised without a parsed byte")

endmodule

// ===== tb/serial_command_line_decoder_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Serial command line decoder testbench
// Feeds text lines byte by byte and checks every decoded command against a
// line parser kept in step with the accepted bytes and the written key table.
// ---------------------------------------------------------------------------
module serial_command_line_decoder_test;
    import scld_pkg::*;

    localparam int ITEM_TARGET   = 1950;
    localparam int PHASE_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [7:0]         letter;
        logic [VALUE_W-1:0] value;
    } t_command;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    scld_byte_if rx_if ();
    scld_cmd_if  cmd_if ();

    serial_command_line_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if.sink),
        .o_cmd   (cmd_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Copy of the key registers and of the line parser state.
    logic [KEY_TABLE_W-1:0] key_table_copy = '0;
    logic [KEY_COUNT_W-1:0] key_count_copy = '0;
    logic [2:0]             line_phase;
    logic [7:0]             line_letter;
    logic [1:0]             line_radix;
    logic [VALUE_W-1:0]     line_value;
    logic [5:0]             line_pos;
    logic                   value_closed;

    t_command   predicted_commands[$];
    logic [7:0] pending_bytes[$];
    int         mismatch_count = 0;
    int         sent_bytes = 0;
    bit         tx_idle_on = 1'b1;
    bit         rx_stall_on = 1'b1;
    int         tx_gap;
    int         rx_stall;

    function automatic bit is_alpha_byte(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_space_byte(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Value of a digit in the given radix, or -1 when the byte is not one.
    function automatic int digit_value(logic [7:0] c, logic [1:0] radix);
        int d;
        d = -1;
        if (c >= "0" && c <= "9") begin
            d = int'(c) - int'("0");
        end else if (radix == RADIX_HEX && c >= "a" && c <= "f") begin
            d = int'(c) - int'("a") + 10;
        end else if (radix == RADIX_HEX && c >= "A" && c <= "F") begin
            d = int'(c) - int'("A") + 10;
        end
        if (radix == RADIX_OCT && d > 7) begin
            d = -1;
        end
        return d;
    endfunction

    task automatic add_digit(input int d);
        logic [63:0] wide;
        int unsigned base;
        base = (line_radix == RADIX_HEX) ? 16 : ((line_radix == RADIX_OCT) ? 8 : 10);
        wide = 64'(line_value) * base + 64'(d);
        line_value = (wide > 64'(VALUE_MAX)) ? VALUE_MAX : wide[VALUE_W-1:0];
    endtask

    task automatic restart_line();
        line_phase   = PH_LETTER;
        line_letter  = 8'd0;
        line_radix   = RADIX_DEC;
        line_value   = '0;
        line_pos     = 6'd0;
        value_closed = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] c);
        int       d;
        int       slots;
        bit       found;
        t_command cmd;
        if (line_phase == PH_SKIP) begin
            if (c == CH_NEWLINE) begin
                restart_line();
            end
            return;
        end
        case (line_phase)
            PH_LETTER: begin
                if (is_alpha_byte(c)) begin
                    line_letter = c;
                    line_phase = PH_SPACE;
                end else begin
                    line_phase = PH_SKIP;
                end
            end
            PH_SPACE: begin
                line_phase = is_space_byte(c) ? PH_FIRST : PH_SKIP;
            end
            PH_FIRST: begin
                if (c == "0") begin
                    line_phase = PH_ZERO;
                end else if (c >= "1" && c <= "9") begin
                    line_radix = RADIX_DEC;
                    add_digit(digit_value(c, RADIX_DEC));
                    line_phase = PH_DIGITS;
                end else begin
                    line_phase = PH_SKIP;
                end
            end
            PH_ZERO: begin
                if (!value_closed) begin
                    if (c == "x" || c == "X") begin
                        line_phase = PH_PREFIX;
                    end else if (c >= "0" && c <= "7") begin
                        line_radix = RADIX_OCT;
                        add_digit(digit_value(c, RADIX_OCT));
                        line_phase = PH_DIGITS;
                    end else begin
                        value_closed = 1'b1;
                    end
                end
            end
            PH_PREFIX: begin
                d = digit_value(c, RADIX_HEX);
                if (!value_closed) begin
                    if (d >= 0) begin
                        line_radix = RADIX_HEX;
                        add_digit(d);
                        line_phase = PH_DIGITS;
                    end else begin
                        value_closed = 1'b1;
                    end
                end
            end
            default: begin
                d = digit_value(c, line_radix);
                if (!value_closed) begin
                    if (d >= 0) begin
                        add_digit(d);
                    end else begin
                        value_closed = 1'b1;
                    end
                end
            end
        endcase

        line_pos = line_pos + 6'd1;
        if (c != CH_NEWLINE && line_pos < 6'(LINE_BYTES - 1)) begin
            return;
        end

        if (line_phase == PH_ZERO || line_phase == PH_PREFIX || line_phase == PH_DIGITS) begin
            slots = (key_count_copy > KEY_SLOTS) ? KEY_SLOTS : int'(key_count_copy);
            found = 1'b0;
            for (int k = 0; k < KEY_SLOTS; k++) begin
                if (!found && k < slots && key_table_copy[8*k +: 8] == line_letter) begin
                    cmd.index = INDEX_W'(k);
                    cmd.letter = line_letter;
                    cmd.value = line_value;
                    predicted_commands.push_back(cmd);
                    found = 1'b1;
                end
            end
        end

        // A line cut off by length drops everything up to the next newline.
        restart_line();
        if (c != CH_NEWLINE) begin
            line_phase = PH_SKIP;
        end
    endtask

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Byte sender: one request per pending byte, with random gaps after each.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                decode_byte(rx_if.rx_byte);
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    rx_if.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    rx_if.rx_byte <= pending_bytes.pop_front();
                    rx_if.valid <= 1'b1;
                    tx_gap = pick_gap(tx_idle_on);
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // Command receiver: checks each request against the oldest prediction.
    always @(posedge i_clk) begin : command_check
        t_command seen;
        t_command want;
        if (!i_rst_n) begin
            cmd_if.ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                seen.index = cmd_if.command_index;
                seen.letter = cmd_if.command_letter;
                seen.value = cmd_if.command_value;
                if (predicted_commands.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("%0t: unexpected command slot %0d letter %02h value %0d",
                                 $realtime, seen.index, seen.letter, seen.value);
                    end
                    mismatch_count++;
                end else begin
                    want = predicted_commands.pop_front();
                    if (seen.index !== want.index || seen.letter !== want.letter ||
                        seen.value !== want.value) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("%0t: command mismatch, expected slot %0d letter %02h value %0d, got slot %0d letter %02h value %0d",
                                     $realtime, want.index, want.letter, want.value,
                                     seen.index, seen.letter, seen.value);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                cmd_if.ready <= 1'b0;
            end else begin
                cmd_if.ready <= 1'b1;
                rx_stall = pick_gap(rx_stall_on);
            end
        end
    end

    task automatic write_register(input logic reg_index, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({reg_index, 3'b000});
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_index == REG_KEY_TABLE) begin
            key_table_copy = data;
        end else begin
            key_count_copy = data[KEY_COUNT_W-1:0];
        end
    endtask

    // Holds off until every byte has gone and every command has come back, or the drain limit is reached.
    task automatic wait_drained();
        int waited;
        waited = 0;
        while ((pending_bytes.size() != 0 || rx_if.valid || predicted_commands.size() != 0) &&
               waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        sent_bytes++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] any_letter();
        if ($urandom_range(0, 1)) begin
            return 8'("A" + $urandom_range(0, 25));
        end
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] line_key();
        logic [7:0] k;
        int         slot;
        slot = $urandom_range(0, KEY_SLOTS - 1);
        k = key_table_copy[8*slot +: 8];
        if ($urandom_range(0, 9) < 7 && is_alpha_byte(k)) begin
            return k;
        end
        return any_letter();
    endfunction

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 5))
            0: return 8'd9;
            1: return 8'd11;
            2: return 8'd12;
            3: return 8'd13;
            default: return 8'd32;
        endcase
    endfunction

    function automatic logic [7:0] non_newline_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_NEWLINE) ? 8'("g") : b;
    endfunction

    task automatic push_number();
        int    r;
        int    n;
        string hex_chars = "0123456789abcdefABCDEF";
        r = $urandom_range(0, 99);
        if (r < 40) begin
            push_byte(8'("1" + $urandom_range(0, 8)));
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 8);
            repeat (n) push_byte(8'("0" + $urandom_range(0, 9)));
        end else if (r < 60) begin
            push_byte("0");
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 8);
            // Now and then an 8 or 9, which ends an octal number.
            repeat (n) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_byte(8'("0" + $urandom_range(8, 9)));
                end else begin
                    push_byte(8'("0" + $urandom_range(0, 7)));
                end
            end
        end else if (r < 85) begin
            push_byte("0");
            push_byte($urandom_range(0, 1) ? 8'("x") : 8'("X"));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 6);
            repeat (n) push_byte(hex_chars[$urandom_range(0, 21)]);
        end else if (r < 93) begin
            push_byte("0");
        end else begin
            push_byte("0");
            push_byte($urandom_range(0, 1) ? 8'("x") : 8'("X"));
        end
    endtask

    task automatic push_command_line();
        push_byte(line_key());
        push_byte(any_blank());
        push_number();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) push_byte(non_newline_byte());
        end
        push_byte(CH_NEWLINE);
    endtask

    task automatic push_broken_line();
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0: begin
                b = non_newline_byte();
                while (is_alpha_byte(b)) b = non_newline_byte();
                push_byte(b);
                push_byte(any_blank());
            end
            1: begin
                push_byte(line_key());
                b = non_newline_byte();
                while (is_space_byte(b)) b = non_newline_byte();
                push_byte(b);
            end
            default: begin
                push_byte(line_key());
                push_byte(any_blank());
                b = non_newline_byte();
                while (b >= "0" && b <= "9") b = non_newline_byte();
                push_byte(b);
            end
        endcase
        push_number();
        push_byte(CH_NEWLINE);
    endtask

    task automatic push_noise();
        repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) != 0) begin
            push_byte(CH_NEWLINE);
        end
    endtask

    // Lines near and past the length limit, mostly digits so they still parse.
    task automatic push_long_line();
        int length;
        length = $urandom_range(28, 45);
        push_byte(line_key());
        push_byte(any_blank());
        push_byte(8'("1" + $urandom_range(0, 8)));
        for (int i = 3; i < length; i++) begin
            if ($urandom_range(0, 4) != 0) begin
                push_byte(8'("0" + $urandom_range(0, 9)));
            end else begin
                push_byte(non_newline_byte());
            end
        end
        push_byte(CH_NEWLINE);
    endtask

    task automatic push_short_line();
        case ($urandom_range(0, 3))
            0: push_byte(CH_NEWLINE);
            1: begin
                push_byte(line_key());
                push_byte(CH_NEWLINE);
            end
            2: begin
                // The newline counts as the blank but still ends the line.
                push_byte(line_key());
                push_byte(CH_NEWLINE);
                push_byte(CH_NEWLINE);
            end
            default: begin
                push_byte(line_key());
                push_byte(any_blank());
                push_byte(CH_NEWLINE);
            end
        endcase
    endtask

    task automatic push_random_line();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            push_command_line();
        end else if (r < 77) begin
            push_broken_line();
        end else if (r < 87) begin
            push_noise();
        end else if (r < 93) begin
            push_long_line();
        end else begin
            push_short_line();
        end
    endtask

    task automatic configure_phase(input int phase);
        logic [KEY_TABLE_W-1:0] key_bytes;
        logic [7:0]             pool [4];
        logic [KEY_COUNT_W-1:0] count;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            key_bytes[8*k +: 8] = any_letter();
        end
        count = KEY_COUNT_W'(KEY_SLOTS);
        case (phase % 6)
            1: count = KEY_COUNT_W'($urandom_range(1, KEY_SLOTS - 1));
            2: begin
                key_bytes = '1;
                count = '0;
            end
            3: begin
                // Few distinct letters, so the lowest matching slot matters.
                for (int i = 0; i < 4; i++) begin
                    pool[i] = any_letter();
                end
                for (int k = 0; k < KEY_SLOTS; k++) begin
                    key_bytes[8*k +: 8] = pool[$urandom_range(0, 3)];
                end
                count = '1;
            end
            4: key_bytes[47:0] = '0;
            default: ;
        endcase
        write_register(REG_KEY_TABLE, key_bytes);
        write_register(REG_KEY_COUNT, CFG_DATA_W'(count));
    endtask

    initial begin
        int  phase;
        int  target;
        bit  paused;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = 8'd0;
        cmd_if.ready = 1'b0;
        restart_line();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Duplicate key in slot 4, and slots that can never match a letter.
        write_register(REG_KEY_TABLE, {"m", 8'hFF, 8'h00, "A", "z", "Z", "b", "A"});
        write_register(REG_KEY_COUNT, CFG_DATA_W'(KEY_SLOTS));
        push_text("A 0x1F\n");
        push_text("z\t09\n");
        push_text("m 0x\n");
        push_text("Q 12\n");
        push_text("5 12\n");
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        phase = 0;
        while (sent_bytes < ITEM_TARGET) begin
            configure_phase(phase);
            tx_idle_on = (phase % 6 != 5);
            rx_stall_on = (phase % 6 != 5);
            target = (sent_bytes + PHASE_ITEMS < ITEM_TARGET) ?
                     sent_bytes + PHASE_ITEMS : ITEM_TARGET;
            paused = 1'b0;
            while (sent_bytes < target) begin
                push_random_line();
                if (!paused && sent_bytes >= target - PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_commands.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #1_500_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
